[hw/rtl/pdhb_pkg.sv]
// Shared types and constants for the polyline distance height brush.
// Used by pdhb_ctrl, pdhb_dp, the top level and the testbench.
`default_nettype none
package pdhb_pkg;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic signed [15:0] height_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] height_out;
    logic               touched;
  } out_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        path_width;
    logic [15:0]        falloff_width;
    logic [14:0]        depth_amount;
    logic signed [15:0] flatten_height;
  } cfg_t;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;

  localparam logic [1:0] MODE_CARVE   = 2'd0;
  localparam logic [1:0] MODE_RAISE   = 2'd1;
  localparam logic [1:0] MODE_FLATTEN = 2'd2;

  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_PATH_W  = 3'd1;
  localparam logic [2:0] CFG_FALL_W  = 3'd2;
  localparam logic [2:0] CFG_DEPTH   = 3'd3;
  localparam logic [2:0] CFG_FLAT_H  = 3'd4;

  localparam logic [4:0] SEG_DIV_STEPS  = 5'd20;
  localparam logic [4:0] SQRT_STEPS     = 5'd22;
  localparam logic [4:0] FALL_DIV_STEPS = 5'd16;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_APPEND, CMD_LOAD, CMD_RDA, CMD_DIFF, CMD_PROD,
    CMD_SUM, CMD_TSEL, CMD_DIV, CMD_CMUL, CMD_CPT, CMD_DSQ, CMD_MIN, CMD_THR,
    CMD_CLASS, CMD_SQRT, CMD_FINIT, CMD_TSQ, CMD_SMOOTH, CMD_WGT, CMD_BMUL,
    CMD_BOUT, CMD_PASS
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_lt2;
    logic t_fixed;
    logic more_seg;
    logic in_path;
    logic beyond;
    logic w_pos;
  } dp_stat_t;

endpackage
`default_nettype wire

[hw/rtl/polyline_distance_height_brush.sv]
// Polyline distance height brush, top level: config registers, sequencer, datapath.
// A pixel with fewer than two vertices passes its height through; otherwise each segment
// takes a pass through the shared divider (skipped at clamped ends), then sqrt, falloff
// divide and blend follow as needed; clear and append do not raise busy. One item at a time.
// The result strobe rises in the cycle busy drops; the receiver cannot stall.
// Synchronous active-low reset clears the vertex count and restores register defaults.
`default_nettype none
module polyline_distance_height_brush #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  pdhb_pkg::in_t       in_data,
  output logic                out_valid,
  output pdhb_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);
  import pdhb_pkg::*;

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_CARVE;
      cfg_r.path_width     <= 16'd64;
      cfg_r.falloff_width  <= 16'd64;
      cfg_r.depth_amount   <= 15'd256;
      cfg_r.flatten_height <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:   cfg_r.mode           <= cfg_data[1:0];
        CFG_PATH_W: cfg_r.path_width     <= cfg_data;
        CFG_FALL_W: cfg_r.falloff_width  <= cfg_data;
        CFG_DEPTH:  cfg_r.depth_amount   <= cfg_data[14:0];
        CFG_FLAT_H: cfg_r.flatten_height <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  pdhb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_data.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  pdhb_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

[hw/rtl/pdhb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pdhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/pdhb_ctrl.sv]
// Sequencer for the brush: walks segments, sqrt, falloff divide and blend.
// Depends on pdhb_pkg; drives pdhb_dp through commands and reads its status.
`default_nettype none
module pdhb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        opcode,
  input  pdhb_pkg::dp_stat_t     stat,
  output pdhb_pkg::dp_cmd_t      cmd,
  output logic                   busy
);
  import pdhb_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001, S_CHK    = 22'h000002, S_SEG0   = 22'h000004,
    S_SEG1   = 22'h000008, S_SEG2   = 22'h000010, S_SEG3   = 22'h000020,
    S_DIV    = 22'h000040, S_SEG4   = 22'h000080, S_SEG5   = 22'h000100,
    S_SEG6   = 22'h000200, S_SEG7   = 22'h000400, S_INFA   = 22'h000800,
    S_INFB   = 22'h001000, S_SQRT   = 22'h002000, S_FINIT  = 22'h004000,
    S_FDIV   = 22'h008000, S_TSQ    = 22'h010000, S_SMOOTH = 22'h020000,
    S_WGT    = 22'h040000, S_BL0    = 22'h080000, S_BL1    = 22'h100000,
    S_PASS   = 22'h200000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_CLEAR:  cmd = CMD_CLEAR;
            OP_APPEND: cmd = CMD_APPEND;
            OP_PIXEL: begin
              cmd       = CMD_LOAD;
              state_nxt = S_CHK;
            end
            default:   cmd = CMD_NONE;
          endcase
        end
      end
      S_CHK: begin
        cmd       = CMD_RDA;
        state_nxt = stat.cnt_lt2 ? S_PASS : S_SEG0;
      end
      S_SEG0: begin
        cmd = CMD_DIFF;
        state_nxt = S_SEG1;
      end
      S_SEG1: begin
        cmd = CMD_PROD;
        state_nxt = S_SEG2;
      end
      S_SEG2: begin
        cmd = CMD_SUM;
        state_nxt = S_SEG3;
      end
      S_SEG3: begin
        cmd = CMD_TSEL;
        if (stat.t_fixed) begin
          state_nxt = S_SEG4;
        end else begin
          state_nxt = S_DIV;
          step_nxt  = SEG_DIV_STEPS - 5'd1;
        end
      end
      S_DIV: begin
        cmd = CMD_DIV;
        if (step_r == 5'd0) state_nxt = S_SEG4;
        else step_nxt = step_r - 5'd1;
      end
      S_SEG4: begin
        cmd = CMD_CMUL;
        state_nxt = S_SEG5;
      end
      S_SEG5: begin
        cmd = CMD_CPT;
        state_nxt = S_SEG6;
      end
      S_SEG6: begin
        cmd = CMD_DSQ;
        state_nxt = S_SEG7;
      end
      S_SEG7: begin
        cmd = CMD_MIN;
        state_nxt = stat.more_seg ? S_SEG0 : S_INFA;
      end
      S_INFA: begin
        cmd = CMD_THR;
        state_nxt = S_INFB;
      end
      S_INFB: begin
        cmd = CMD_CLASS;
        if (stat.in_path) begin
          state_nxt = S_BL0;
        end else if (stat.beyond) begin
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_SQRT;
          step_nxt  = SQRT_STEPS - 5'd1;
        end
      end
      S_SQRT: begin
        cmd = CMD_SQRT;
        if (step_r == 5'd0) state_nxt = S_FINIT;
        else step_nxt = step_r - 5'd1;
      end
      S_FINIT: begin
        cmd       = CMD_FINIT;
        state_nxt = S_FDIV;
        step_nxt  = FALL_DIV_STEPS - 5'd1;
      end
      S_FDIV: begin
        cmd = CMD_DIV;
        if (step_r == 5'd0) state_nxt = S_TSQ;
        else step_nxt = step_r - 5'd1;
      end
      S_TSQ: begin
        cmd = CMD_TSQ;
        state_nxt = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd = CMD_SMOOTH;
        state_nxt = S_WGT;
      end
      S_WGT: begin
        cmd = CMD_WGT;
        state_nxt = stat.w_pos ? S_BL0 : S_PASS;
      end
      S_BL0: begin
        cmd = CMD_BMUL;
        state_nxt = S_BL1;
      end
      S_BL1: begin
        cmd = CMD_BOUT;
        state_nxt = S_IDLE;
      end
      S_PASS: begin
        cmd = CMD_PASS;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 5'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && opcode == OP_PIXEL) |=> (state_r == S_CHK))
    else $error("pixel accept did not start a walk");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_SEG4))
    else $error("segment divide left to a wrong state");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && step_r == 5'd0) |=> (state_r == S_FINIT))
    else $error("sqrt did not finish on its last step");
endmodule
`default_nettype wire

[hw/rtl/pdhb_dp.sv]
// Datapath: vertex store, segment distance, sqrt, shared divider and blend.
// Depends on pdhb_pkg and pdhb_ram; commanded by pdhb_ctrl.
`default_nettype none
module pdhb_dp #(
  parameter int MAX_VERTICES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  pdhb_pkg::dp_cmd_t   cmd,
  input  pdhb_pkg::in_t       in_data,
  input  pdhb_pkg::cfg_t      cfg,
  output pdhb_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output pdhb_pkg::out_t      out_data
);
  import pdhb_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [CW-1:0]      count_r, idx_r;
  logic signed [17:0] px_r, py_r;
  logic signed [15:0] cur_r;
  logic signed [15:0] ax_r, ay_r, bx_r, by_r;
  logic signed [16:0] abx_r, aby_r;
  logic signed [18:0] apx_r, apy_r;
  logic signed [33:0] m1_r, m2_r;
  logic signed [35:0] m3_r, m4_r;
  logic signed [35:0] len2_r;
  logic signed [37:0] d_r;
  logic [20:0]        t_r;
  logic [36:0]        rem_r;
  logic [35:0]        den_r;
  logic [19:0]        quo_r;
  logic signed [38:0] mx_r, my_r;
  logic signed [21:0] dx_r, dy_r;
  logic signed [43:0] dsx_r, dsy_r;
  logic [44:0]        dmin_r;
  logic [31:0]        pw2_r;
  logic [33:0]        tot2_r;
  logic [43:0]        sv_r, sres_r, sbit_r;
  logic [15:0]        t2_r;
  logic [17:0]        s_r;
  logic [16:0]        w_r;
  logic signed [35:0] prod_r;
  logic               out_vld_r;
  out_t               out_r;

  logic               we;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic signed [15:0] rx, ry;

  pdhb_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_data.vertex_x, in_data.vertex_y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rx = $signed(rdata[31:16]);
  assign ry = $signed(rdata[15:0]);
  assign we = (cmd == CMD_APPEND) && (count_r < CW'(MAX_VERTICES));

  always_comb begin
    case (cmd)
      CMD_RDA: raddr = AW'(1);
      CMD_MIN: raddr = idx_r[AW-1:0] + AW'(1);
      default: raddr = '0;
    endcase
  end

  // status for the sequencer
  logic [CW-1:0] idx_inc;
  assign idx_inc       = idx_r + CW'(1);
  assign stat.cnt_lt2  = (count_r < CW'(2));
  assign stat.t_fixed  = (len2_r == '0) || (d_r <= 38'sd0) || (d_r >= 38'(len2_r));
  assign stat.more_seg = (idx_inc < count_r);
  assign stat.in_path  = (dmin_r <= 45'(pw2_r));
  assign stat.beyond   = (dmin_r >= 45'(tot2_r)) || (cfg.falloff_width == 16'd0);
  assign stat.w_pos    = (s_r < 18'd65536);

  // shared restoring divider step
  logic [36:0] r2;
  logic        qbit;
  assign r2   = {rem_r[35:0], 1'b0};
  assign qbit = (r2 >= {1'b0, den_r});

  // sqrt step
  logic [43:0] ssum;
  assign ssum = sres_r + sbit_r;

  // segment arithmetic
  logic signed [39:0] rndx, rndy;
  logic signed [20:0] cx, cy;
  logic signed [44:0] dsq;
  assign rndx = 40'(mx_r) + 40'sd524288;
  assign rndy = 40'(my_r) + 40'sd524288;
  assign cx   = 21'(ax_r) + 21'($signed(rndx[39:20]));
  assign cy   = 21'(ay_r) + 21'($signed(rndy[39:20]));
  assign dsq  = 45'(dsx_r) + 45'(dsy_r);

  // falloff and blend arithmetic
  logic signed [22:0] xoff;
  logic [16:0]        tq;
  logic [33:0]        tsq;
  logic [17:0]        fac;
  logic [33:0]        smul;
  logic signed [17:0] diff;
  logic signed [36:0] prnd;
  logic signed [21:0] res;
  logic signed [15:0] res_sat;
  assign xoff = 23'($signed({1'b0, sres_r[21:0]})) - 23'($signed({1'b0, cfg.path_width, 4'b0}));
  assign tq   = {1'b0, quo_r[15:0]};
  assign tsq  = tq * tq;
  assign fac  = 18'd196608 - {tq, 1'b0};
  assign smul = t2_r * fac;
  assign prnd = 37'(prod_r) + 37'sd32768;
  assign res  = 22'(cur_r) + 22'($signed(prnd[36:16]));

  always_comb begin
    case (cfg.mode)
      MODE_CARVE:   diff = -18'($signed({1'b0, cfg.depth_amount}));
      MODE_RAISE:   diff = 18'($signed({1'b0, cfg.depth_amount}));
      MODE_FLATTEN: diff = 18'(cfg.flatten_height) - 18'(cur_r);
      default:      diff = 18'sd0;
    endcase
    if (res > 22'sd32767)       res_sat = 16'sh7fff;
    else if (res < -22'sd32768) res_sat = -16'sh8000;
    else                        res_sat = res[15:0];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        px_r  <= $signed({2'b0, in_data.pixel_x, 4'b0});
        py_r  <= $signed({2'b0, in_data.pixel_y, 4'b0});
        cur_r <= in_data.height_in;
        idx_r <= CW'(1);
      end
      CMD_RDA: begin
        ax_r <= rx;
        ay_r <= ry;
      end
      CMD_DIFF: begin
        bx_r  <= rx;
        by_r  <= ry;
        abx_r <= 17'(rx) - 17'(ax_r);
        aby_r <= 17'(ry) - 17'(ay_r);
        apx_r <= 19'(px_r) - 19'(ax_r);
        apy_r <= 19'(py_r) - 19'(ay_r);
      end
      CMD_PROD: begin
        m1_r <= 34'(abx_r) * 34'(abx_r);
        m2_r <= 34'(aby_r) * 34'(aby_r);
        m3_r <= 36'(apx_r) * 36'(abx_r);
        m4_r <= 36'(apy_r) * 36'(aby_r);
      end
      CMD_SUM: begin
        len2_r <= 36'(m1_r) + 36'(m2_r);
        d_r    <= 38'(m3_r) + 38'(m4_r);
      end
      CMD_TSEL: begin
        if ((len2_r == '0) || (d_r <= 38'sd0)) t_r <= '0;
        else t_r <= 21'd1048576;
        rem_r <= 37'(d_r[35:0]);
        den_r <= len2_r[35:0];
        quo_r <= '0;
      end
      CMD_DIV: begin
        rem_r <= qbit ? (r2 - {1'b0, den_r}) : r2;
        quo_r <= {quo_r[18:0], qbit};
        t_r   <= {1'b0, quo_r[18:0], qbit};
      end
      CMD_CMUL: begin
        mx_r <= 39'(abx_r) * 39'($signed({1'b0, t_r}));
        my_r <= 39'(aby_r) * 39'($signed({1'b0, t_r}));
      end
      CMD_CPT: begin
        dx_r <= 22'(px_r) - 22'(cx);
        dy_r <= 22'(py_r) - 22'(cy);
      end
      CMD_DSQ: begin
        dsx_r <= 44'(dx_r) * 44'(dx_r);
        dsy_r <= 44'(dy_r) * 44'(dy_r);
      end
      CMD_MIN: begin
        if (idx_r == CW'(1) || dsq[44:0] < dmin_r) dmin_r <= dsq[44:0];
        idx_r <= idx_inc;
        ax_r  <= bx_r;
        ay_r  <= by_r;
      end
      CMD_THR: begin
        pw2_r  <= cfg.path_width * cfg.path_width;
        tot2_r <= 34'(({1'b0, cfg.path_width} + {1'b0, cfg.falloff_width}) *
                      ({1'b0, cfg.path_width} + {1'b0, cfg.falloff_width}));
      end
      CMD_CLASS: begin
        w_r    <= 17'd65536;
        sv_r   <= {dmin_r[35:0], 8'b0};
        sres_r <= '0;
        sbit_r <= 44'd1 << 42;
      end
      CMD_SQRT: begin
        if (sv_r >= ssum) begin
          sv_r   <= sv_r - ssum;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      CMD_FINIT: begin
        rem_r <= xoff[22] ? '0 : 37'(xoff[21:0]);
        den_r <= 36'({cfg.falloff_width, 4'b0});
        quo_r <= '0;
      end
      CMD_TSQ:    t2_r <= tsq[31:16];
      CMD_SMOOTH: s_r  <= smul[33:16];
      CMD_WGT:    w_r  <= 17'd65536 - s_r[16:0];
      CMD_BMUL:   prod_r <= 36'(diff) * 36'($signed({1'b0, w_r}));
      CMD_BOUT: begin
        out_r.height_out <= res_sat;
        out_r.touched    <= 1'b1;
      end
      CMD_PASS: begin
        out_r.height_out <= cur_r;
        out_r.touched    <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= (cmd == CMD_BOUT) || (cmd == CMD_PASS);
      if (cmd == CMD_CLEAR) count_r <= '0;
      else if (we)          count_r <= count_r + CW'(1);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ($past(cmd) == CMD_BOUT || $past(cmd) == CMD_PASS))
    else $error("result strobe without a finishing command");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTICES))
    else $error("vertex count past store depth");

  a_touch_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_BOUT) |-> (w_r != 17'd0))
    else $error("touched result with zero weight");
endmodule
`default_nettype wire

[test/polyline_distance_height_brush_test.sv]
// Testbench for polyline_distance_height_brush: directed table, then random polylines.
// Results are checked against table values or an in-bench predictor; it uses pdhb_pkg and the top level.
`default_nettype none
module polyline_distance_height_brush_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdhb_pkg::*;

  localparam int VERT_DEPTH = 256;
  localparam int STALL_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  polyline_distance_height_brush dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  cfg_t brush_cfg;
  longint vx_mem[VERT_DEPTH];
  longint vy_mem[VERT_DEPTH];
  int vert_count;

  out_t heights_due[$];
  int errors = 0;
  int pixels_sent = 0;
  int items_sent = 0;
  int touched_seen = 0;
  int idle_pct = 0;

  typedef struct {
    in_t item;
    bit  known;
    out_t want;
  } row_t;
  row_t rows[$];

  function automatic longint sq_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint seg_dist_sq(longint px, longint py, longint ax, longint ay,
                                         longint bx, longint by);
    longint abx, aby, apx, apy, len2, d, t, cx, cy;
    abx = bx - ax; aby = by - ay;
    apx = px - ax; apy = py - ay;
    len2 = abx * abx + aby * aby;
    if (len2 == 0) return apx * apx + apy * apy;
    d = apx * abx + apy * aby;
    if (d <= 0) t = 0;
    else if (d >= len2) t = 64'sd1 << 20;
    else t = (d <<< 20) / len2;
    cx = ax + ((abx * t + (64'sd1 << 19)) >>> 20);
    cy = ay + ((aby * t + (64'sd1 << 19)) >>> 20);
    return (px - cx) * (px - cx) + (py - cy) * (py - cy);
  endfunction

  function automatic longint brush_weight(longint dmin);
    longint pw, fw, tot, t, t2, s;
    pw = longint'(brush_cfg.path_width);
    fw = longint'(brush_cfg.falloff_width);
    tot = pw + fw;
    if (dmin <= pw * pw) return 65536;
    if (dmin >= tot * tot || fw == 0) return 0;
    t = sq_root(longint'(dmin) << 8) - pw * 16;
    if (t < 0) t = 0;
    t = (t * 65536) / (fw * 16);
    if (t > 65536) t = 65536;
    t2 = (t * t) >>> 16;
    s = (t2 * (3 * 65536 - 2 * t)) >>> 16;
    return 65536 - s;
  endfunction

  // advance the predictor by one accepted item; has_out tells whether a result follows
  task automatic predict_height(input in_t it, output bit has_out, output out_t res);
    longint cur, target, w, dmin, d, px, py, nh;
    has_out = 1'b0;
    res = '0;
    case (it.opcode)
      OP_CLEAR: vert_count = 0;
      OP_APPEND: begin
        if (vert_count < VERT_DEPTH) begin
          vx_mem[vert_count] = longint'(it.vertex_x);
          vy_mem[vert_count] = longint'(it.vertex_y);
          vert_count++;
        end
      end
      OP_PIXEL: begin
        has_out = 1'b1;
        cur = longint'(it.height_in);
        res.height_out = it.height_in;
        if (vert_count >= 2) begin
          px = longint'(it.pixel_x) * 16;
          py = longint'(it.pixel_y) * 16;
          dmin = seg_dist_sq(px, py, vx_mem[0], vy_mem[0], vx_mem[1], vy_mem[1]);
          for (int i = 2; i < vert_count; i++) begin
            d = seg_dist_sq(px, py, vx_mem[i-1], vy_mem[i-1], vx_mem[i], vy_mem[i]);
            if (d < dmin) dmin = d;
          end
          w = brush_weight(dmin);
          if (w > 0) begin
            case (brush_cfg.mode)
              MODE_CARVE:   target = cur - longint'(brush_cfg.depth_amount);
              MODE_RAISE:   target = cur + longint'(brush_cfg.depth_amount);
              MODE_FLATTEN: target = longint'(brush_cfg.flatten_height);
              default:      target = cur;
            endcase
            nh = cur + (((target - cur) * w + 32768) >>> 16);
            if (nh > 32767) nh = 32767;
            if (nh < -32768) nh = -32768;
            res.height_out = 16'(nh);
            res.touched = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // result checker: the receiver cannot stall, every strobe is a transfer
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (heights_due.size() == 0) begin
        $error("unexpected result height_out=%0d touched=%0b",
               out_data.height_out, out_data.touched);
        errors++;
      end else begin
        want = heights_due.pop_front();
        if (out_data.height_out !== want.height_out) begin
          $error("height_out expected %0d actual %0d", want.height_out, out_data.height_out);
          errors++;
        end
        if (out_data.touched !== want.touched) begin
          $error("touched expected %0b actual %0b", want.touched, out_data.touched);
          errors++;
        end
        if (out_data.touched === 1'b1) touched_seen++;
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one item; start stays high when the next item follows at once
  task automatic send_item(input in_t it, input bit known, input out_t want);
    bit has_out;
    out_t res;
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predict_height(it, has_out, res);
    if (has_out) begin
      heights_due.insert(heights_due.size(), known ? want : res);
      pixels_sent++;
    end
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send(input in_t it);
    send_item(it, 1'b0, '0);
  endtask

  // hold off until every pending result has arrived and the block is quiet
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (heights_due.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:   brush_cfg.mode = val[1:0];
      CFG_PATH_W: brush_cfg.path_width = val;
      CFG_FALL_W: brush_cfg.falloff_width = val;
      CFG_DEPTH:  brush_cfg.depth_amount = val[14:0];
      CFG_FLAT_H: brush_cfg.flatten_height = val;
      default: ;
    endcase
  endtask

  function automatic in_t make_item(logic [1:0] op, int vx, int vy, int px, int py, int h);
    in_t it;
    it.opcode = op;
    it.vertex_x = 16'(vx);
    it.vertex_y = 16'(vy);
    it.pixel_x = 12'(px);
    it.pixel_y = 12'(py);
    it.height_in = 16'(h);
    return it;
  endfunction

  task automatic add_row(input in_t it, input bit known, input int h, input bit tch);
    row_t r;
    r.item = it;
    r.known = known;
    r.want.height_out = 16'(h);
    r.want.touched = tch;
    rows.insert(rows.size(), r);
  endtask

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // clear, load a random polyline, then brush pixels around it
  task automatic send_stroke(input int nverts);
    int cx, cy, vx, vy, npix;
    int vxs[$], vys[$];
    send(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
    cx = $urandom_range(2000, 30000);
    cy = $urandom_range(2000, 30000);
    for (int i = 0; i < nverts; i++) begin
      if ($urandom_range(9) == 0 && i > 0) begin
        vx = vxs[i-1]; vy = vys[i-1];
      end else begin
        vx = clip(cx + int'($urandom_range(1600)) - 800, -32768, 32767);
        vy = clip(cy + int'($urandom_range(1600)) - 800, -32768, 32767);
      end
      vxs.insert(vxs.size(), vx); vys.insert(vys.size(), vy);
      send(make_item(OP_APPEND, vx, vy, $urandom, $urandom, $urandom));
    end
    npix = $urandom_range(4, 14);
    for (int i = 0; i < npix; i++) begin
      int k;
      k = $urandom_range(nverts > 0 ? nverts - 1 : 0);
      vx = (nverts > 0) ? vxs[k] / 16 : cx / 16;
      vy = (nverts > 0) ? vys[k] / 16 : cy / 16;
      send(make_item(OP_PIXEL, $urandom, $urandom,
                     clip(vx + int'($urandom_range(40)) - 20, 0, 4095),
                     clip(vy + int'($urandom_range(40)) - 20, 0, 4095), $urandom));
    end
  endtask

  initial begin
    int idle_plan[4];
    in_t it;
    idle_plan = '{0, 56, 0, 28};
    brush_cfg.mode = MODE_CARVE;
    brush_cfg.path_width = 16'd64;
    brush_cfg.falloff_width = 16'd64;
    brush_cfg.depth_amount = 15'd256;
    brush_cfg.flatten_height = '0;
    vert_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    add_row(make_item(OP_PIXEL, 0, 0, 5, 5, -32768), 1'b1, -32768, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 4095, 4095, 32767), 1'b1, 32767, 1'b0);
    add_row(make_item(2'd3, 0, 0, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_APPEND, 32767, 32767, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 2047, 2047, 'h1234), 1'b1, 'h1234, 1'b0);
    add_row(make_item(OP_APPEND, -32768, -32768, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 0, 0, 100), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 4095, 4095, -100), 1'b0, 0, 1'b0);
    add_row(make_item(OP_CLEAR, 0, 0, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_APPEND, 160, 160, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_APPEND, 160, 160, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 10, 10, 0), 1'b1, -256, 1'b1);
    add_row(make_item(OP_PIXEL, 0, 0, 11, 10, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 14, 10, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 100, 100, 500), 1'b1, 500, 1'b0);
    add_row(make_item(OP_APPEND, 800, 160, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 30, 10, -32768), 1'b1, -32768, 1'b1);
    add_row(make_item(OP_PIXEL, 0, 0, 30, 12, 1000), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 5, 10, 1000), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 60, 10, 1000), 1'b0, 0, 1'b0);
    add_row(make_item(OP_CLEAR, 0, 0, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(OP_PIXEL, 0, 0, 10, 10, 777), 1'b1, 777, 1'b0);
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].want);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = idle_plan[ph % 4];
      case (ph)
        0: begin
          write_reg(CFG_PATH_W, 16'd0); write_reg(CFG_FALL_W, 16'd0);
          write_reg(CFG_DEPTH, 16'd0); write_reg(CFG_MODE, 16'(MODE_CARVE));
        end
        1: begin
          write_reg(CFG_PATH_W, 16'hFFFF); write_reg(CFG_FALL_W, 16'hFFFF);
          write_reg(CFG_DEPTH, 16'h7FFF); write_reg(CFG_MODE, 16'(MODE_RAISE));
        end
        2: begin
          write_reg(CFG_PATH_W, 16'd0); write_reg(CFG_FALL_W, 16'd400);
          write_reg(CFG_FLAT_H, 16'h8000); write_reg(CFG_MODE, 16'(MODE_FLATTEN));
        end
        3: begin
          write_reg(CFG_FLAT_H, 16'h7FFF); write_reg(CFG_MODE, 16'(MODE_FLATTEN));
        end
        4: write_reg(CFG_MODE, 16'd3);
        default: begin
          write_reg(CFG_MODE, 16'($urandom_range(2)));
          write_reg(CFG_PATH_W, 16'($urandom_range(300)));
          write_reg(CFG_FALL_W, 16'($urandom_range(400)));
          write_reg(CFG_DEPTH, 16'($urandom));
          write_reg(CFG_FLAT_H, 16'($urandom));
        end
      endcase
      if (ph == 5) begin
        // fill the store past capacity; extra appends are dropped
        send(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
        for (int i = 0; i < VERT_DEPTH + 4; i++)
          send(make_item(OP_APPEND, 8000 + 16 * i, 8000 + 4 * (i % 7), 0, 0, 0));
        for (int i = 0; i < 3; i++)
          send(make_item(OP_PIXEL, 0, 0, $urandom_range(490, 780), 500, $urandom));
      end
      for (int n = 0; n < 150; ) begin
        if ($urandom_range(9) == 0) begin
          it = in_t'($urandom_range(1) ? {$urandom, $urandom, $urandom}
                                       : ~{$urandom, $urandom, $urandom});
          send(it);
          n++;
        end else begin
          int nv;
          nv = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
          send_stroke(nv);
          n += nv + 10;
        end
      end
      drain();
    end

    drain();
    $display("covered %0d items, %0d pixel results (%0d touched), 8 register settings",
             items_sent, pixels_sent, touched_seen);
    $display("sender idling at 0, 28 and 56 percent, store filled past capacity once");
    if (errors == 0 && heights_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (heights_due.size() != 0) $error("%0d results never arrived", heights_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hw/rtl/pdhb_pkg.sv
hw/rtl/pdhb_ram.sv
hw/rtl/pdhb_ctrl.sv
hw/rtl/pdhb_dp.sv
hw/rtl/polyline_distance_height_brush.sv
test/polyline_distance_height_brush_test.sv
